/* design/fne_pkg.sv */
// shared types and constants for the fasta nucleotide encoder
package fne_pkg;

  typedef enum logic [0:0] {
    OP_DATA = 1'b0,
    OP_EOF  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_SYMBOL  = 2'd0,
    KIND_ERROR   = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_HEADER = 3'd1,
    ERR_LENGTH    = 3'd2,
    ERR_LETTER    = 3'd3,
    ERR_MIXED     = 3'd4,
    ERR_NO_RECORD = 3'd5,
    ERR_OVERFLOW  = 3'd6
  } err_t;

  typedef enum logic [1:0] {
    ALPHA_UNKNOWN = 2'd0,
    ALPHA_DNA     = 2'd1,
    ALPHA_RNA     = 2'd2
  } alpha_t;

  localparam logic [7:0] CHAR_GT      = 8'h3E;
  localparam logic [7:0] CHAR_NL      = 8'h0A;
  localparam logic [7:0] CHAR_A       = 8'h41;
  localparam logic [7:0] CHAR_C       = 8'h43;
  localparam logic [7:0] CHAR_G       = 8'h47;
  localparam logic [7:0] CHAR_T       = 8'h54;
  localparam logic [7:0] CHAR_U       = 8'h55;
  localparam logic [7:0] CHAR_Z       = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  typedef struct packed {
    op_t        op;
    logic [7:0] byte_in;
  } src_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [1:0]  code;
    logic [15:0] record_index;
    logic [11:0] position;
    err_t        error_code;
    logic [16:0] record_count;
    logic [12:0] record_length;
    logic        is_rna;
  } res_item_t;

endpackage

/* design/fne_core.sv */
// parser state and per-byte decision logic
module fne_core #(
  parameter int unsigned MAX_RECORDS = 65536,
  parameter int unsigned MAX_LENGTH  = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  fne_pkg::src_item_t item,
  output logic              emit,
  output fne_pkg::res_item_t result
);
  import fne_pkg::*;

  localparam int RW = $clog2(MAX_RECORDS + 1);
  localparam int LW = $clog2(MAX_LENGTH + 1);

  logic          in_header, in_header_next;
  logic          seen_first_byte, seen_first_byte_next;
  logic [RW-1:0] records_seen, records_seen_next;
  logic [LW-1:0] current_length, current_length_next;
  logic [LW-1:0] reference_length, reference_length_next;
  logic          reference_set, reference_set_next;
  alpha_t        alphabet_seen, alphabet_seen_next;
  logic          halted, halted_next;

  logic [7:0]    up;
  logic          is_letter;
  logic          bad_letter;
  logic [1:0]    sym;
  alpha_t        alpha;
  logic          mismatch;
  logic [RW-1:0] rec_idx;

  // fold lower case onto upper case
  always_comb begin
    if (item.byte_in >= CHAR_LOWER_A && item.byte_in <= CHAR_LOWER_Z) begin
      up = item.byte_in - CASE_OFFSET;
    end else begin
      up = item.byte_in;
    end
    is_letter = (up >= CHAR_A) && (up <= CHAR_Z);
  end

  always_comb begin
    bad_letter = 1'b0;
    alpha      = ALPHA_UNKNOWN;
    sym        = CODE_A;
    unique case (up)
      CHAR_A: sym = CODE_A;
      CHAR_C: sym = CODE_C;
      CHAR_G: sym = CODE_G;
      CHAR_T: begin
        sym   = CODE_T;
        alpha = ALPHA_DNA;
      end
      CHAR_U: begin
        sym   = CODE_T;
        alpha = ALPHA_RNA;
      end
      default: bad_letter = 1'b1;
    endcase
  end

  // closing record differs from the reference length
  assign mismatch = (records_seen != '0) && reference_set &&
                    (current_length != reference_length);
  assign rec_idx  = records_seen - RW'(1);

  always_comb begin
    in_header_next        = in_header;
    seen_first_byte_next  = seen_first_byte;
    records_seen_next     = records_seen;
    current_length_next   = current_length;
    reference_length_next = reference_length;
    reference_set_next    = reference_set;
    alphabet_seen_next    = alphabet_seen;
    halted_next           = halted;
    emit                  = 1'b0;
    result                = '0;

    if (!halted) begin
      if (item.op == OP_EOF) begin
        emit        = 1'b1;
        halted_next = 1'b1;
        if (records_seen == '0) begin
          result.kind       = KIND_ERROR;
          result.error_code = ERR_NO_RECORD;
        end else if (mismatch) begin
          result.kind       = KIND_ERROR;
          result.error_code = ERR_LENGTH;
        end else begin
          result.kind          = KIND_SUMMARY;
          result.record_count  = 17'(records_seen);
          result.record_length = reference_set ? 13'(reference_length)
                                               : 13'(current_length);
          result.is_rna        = (alphabet_seen == ALPHA_RNA);
        end
      end else begin
        seen_first_byte_next = 1'b1;
        if (!seen_first_byte && item.byte_in != CHAR_GT) begin
          emit              = 1'b1;
          halted_next       = 1'b1;
          result.kind       = KIND_ERROR;
          result.error_code = ERR_NO_HEADER;
        end else if (in_header) begin
          if (item.byte_in == CHAR_NL) begin
            in_header_next = 1'b0;
          end
        end else if (item.byte_in == CHAR_GT) begin
          if (mismatch) begin
            emit              = 1'b1;
            halted_next       = 1'b1;
            result.kind       = KIND_ERROR;
            result.error_code = ERR_LENGTH;
          end else if (records_seen >= RW'(MAX_RECORDS)) begin
            emit              = 1'b1;
            halted_next       = 1'b1;
            result.kind       = KIND_ERROR;
            result.error_code = ERR_OVERFLOW;
          end else begin
            // first non-empty record fixes the reference length
            if (records_seen != '0 && !reference_set && current_length != '0) begin
              reference_set_next    = 1'b1;
              reference_length_next = current_length;
            end
            records_seen_next   = records_seen + RW'(1);
            current_length_next = '0;
            in_header_next      = 1'b1;
          end
        end else if (is_letter) begin
          emit = 1'b1;
          if (bad_letter) begin
            halted_next       = 1'b1;
            result.kind       = KIND_ERROR;
            result.error_code = ERR_LETTER;
          end else if (alpha != ALPHA_UNKNOWN && alphabet_seen != ALPHA_UNKNOWN &&
                       alphabet_seen != alpha) begin
            halted_next       = 1'b1;
            result.kind       = KIND_ERROR;
            result.error_code = ERR_MIXED;
          end else if (current_length >= LW'(MAX_LENGTH)) begin
            halted_next       = 1'b1;
            result.kind       = KIND_ERROR;
            result.error_code = ERR_OVERFLOW;
          end else begin
            if (alphabet_seen == ALPHA_UNKNOWN) begin
              alphabet_seen_next = alpha;
            end
            result.kind         = KIND_SYMBOL;
            result.code         = sym;
            result.record_index = 16'(rec_idx);
            result.position     = 12'(current_length);
            current_length_next = current_length + LW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_header        <= 1'b0;
      seen_first_byte  <= 1'b0;
      records_seen     <= '0;
      current_length   <= '0;
      reference_length <= '0;
      reference_set    <= 1'b0;
      alphabet_seen    <= ALPHA_UNKNOWN;
      halted           <= 1'b0;
    end else if (fire) begin
      in_header        <= in_header_next;
      seen_first_byte  <= seen_first_byte_next;
      records_seen     <= records_seen_next;
      current_length   <= current_length_next;
      reference_length <= reference_length_next;
      reference_set    <= reference_set_next;
      alphabet_seen    <= alphabet_seen_next;
      halted           <= halted_next;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halted flag dropped without reset");

  a_quiet_when_halted: assert property (@(posedge clk) disable iff (rst)
    halted |-> !emit)
    else $error("result produced after halt");

  a_end_halts: assert property (@(posedge clk) disable iff (rst)
    fire && emit && result.kind != KIND_SYMBOL |=> halted)
    else $error("error or summary did not halt the parser");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    current_length <= LW'(MAX_LENGTH) && records_seen <= RW'(MAX_RECORDS))
    else $error("counter beyond its limit");

endmodule

/* design/fasta_nucleotide_encoder.sv */
// top level of the fasta nucleotide encoder: input stage, parser core, result register
//
// usage
//   src channel: one request per file byte (op data) or one end-of-file request.
//   res channel: nucleotide symbols with record index and position, a single
//   error, or the end summary (record count, common length, rna flag).
//   header bytes, newlines and non-letters give no result unless they raise an error.
// result path
//   an accepted request is held in the input stage register, decoded from there, and
//   its result (if any) is loaded into the result register, where res_valid rises.
//   one request per cycle unless a request with a result meets a full result register;
//   set by the single decode step between the input stage register and the result
//   register, which updates the parser state.
// reset
//   rst (synchronous) empties both registers and clears the parser state.
//   after an error or an end summary the block takes requests but produces
//   nothing until the next reset.
// stall
//   while a result waits for res_ready, a request that produces no result
//   still drains; one that produces a result waits in the input stage and
//   src_ready drops only once that stage is also held.
module fasta_nucleotide_encoder #(
  parameter int unsigned MAX_RECORDS = 65536,
  parameter int unsigned MAX_LENGTH  = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_ready,
  input  fne_pkg::src_item_t src_data,
  output logic               res_valid,
  input  logic               res_ready,
  output fne_pkg::res_item_t res_data
);
  import fne_pkg::*;

  // input stage register
  logic      stage_valid;
  src_item_t stage_item;

  // decode outputs
  logic      core_emit;
  res_item_t core_result;
  logic      core_fire;
  logic      res_free;

  // result slot is free when empty or being taken this cycle
  assign res_free  = !res_valid || res_ready;
  // staged request commits when it needs no slot or the slot is free
  assign core_fire = stage_valid && (!core_emit || res_free);
  assign src_ready = !stage_valid || core_fire;

  fne_core #(
    .MAX_RECORDS(MAX_RECORDS),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .fire  (core_fire),
    .item  (stage_item),
    .emit  (core_emit),
    .result(core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (src_valid && src_ready) begin
      stage_valid <= 1'b1;
    end else if (core_fire) begin
      stage_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      stage_item <= src_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (core_fire && core_emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_fire && core_emit) begin
      res_data <= core_result;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !(core_fire && core_emit))
    else $error("pending result overwritten");

  a_stage_drains: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !core_emit |-> core_fire)
    else $error("request without result held in the input stage");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !stage_valid |-> src_ready)
    else $error("empty input stage refused a request");

endmodule
